[rtl/console_line_buffer_macros.svh]
// Assertion macros for the console line buffer RTL.
`ifndef CONSOLE_LINE_BUFFER_MACROS_SVH
`define CONSOLE_LINE_BUFFER_MACROS_SVH

`ifndef SYNTHESIS

// Checked on the rising edge of i_clk, switched off while i_rst_n is low.
`define CLB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on the rising edge of i_clk at all times, reset included.
`define CLB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define CLB_ASSERT(lbl, prop, msg)
`define CLB_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[rtl/clb_pkg.sv]
// Types and constants shared by the console line buffer modules.
`timescale 1ns / 1ps

package clb_pkg;

    // Default sizes of the byte store and of one read.
    localparam int LINE_SIZE_DEF = 256;
    localparam int MAX_READ_DEF  = 64;

    // Field widths.
    localparam int BYTE_W = 8;
    localparam int SIZE_W = 7;
    localparam int FILL_W = 8;
    localparam int LINE_W = 8;

    // Character codes with a special meaning.
    localparam logic [BYTE_W-1:0] CH_ERASE = 8'd127;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'd0;

    // Saturation point of the line counter.
    localparam logic [LINE_W-1:0] LINE_CNT_MAX = 8'd255;

    // Line discipline modes.
    typedef enum logic [1:0] {
        MODE_COOKED = 2'd0,
        MODE_RARE   = 2'd1,
        MODE_RAW    = 2'd2
    } t_mode;

    // Mode code that is not a mode; a write of it is ignored.
    localparam logic [1:0] MODE_INVALID = 2'd3;

    // Input operations.
    typedef enum logic {
        OP_APPEND = 1'b0,
        OP_READ   = 1'b1
    } t_op;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_STORED     = 3'd0,
        ST_ERASED     = 3'd1,
        ST_IGNORED    = 3'd2,
        ST_OVERFLOW   = 3'd3,
        ST_READ_BYTE  = 3'd4,
        ST_READ_EMPTY = 3'd5,
        ST_WOULD_BLK  = 3'd6
    } t_status;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_ERASE_RD,
        S_READ_RD,
        S_OUT
    } t_state;

    // One result item as it leaves the controller.
    typedef struct packed {
        t_status           status;
        logic [BYTE_W-1:0] data_byte;
        logic              echo;
        logic              last;
        logic              ready_res;
        logic [FILL_W-1:0] fill_level;
    } t_result;

endpackage

[rtl/clb_ram.sv]
// Generic single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps

module clb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read of the same address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/clb_ctrl.sv]
// Line discipline controller: buffer pointers, store access sequencing and result register.
`timescale 1ns / 1ps
`include "console_line_buffer_macros.svh"

module clb_ctrl #(
    parameter int LINE_SIZE = clb_pkg::LINE_SIZE_DEF,
    parameter int MAX_READ  = clb_pkg::MAX_READ_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Mode and buffer clear from the register block
    input  clb_pkg::t_mode                i_mode,
    input  logic                          i_clear,
    output logic                          o_idle,
    // Incoming item
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_op,
    input  logic [clb_pkg::BYTE_W-1:0]    i_key,
    input  logic [clb_pkg::SIZE_W-1:0]    i_size,
    // Byte store port
    output logic                          o_mem_we,
    output logic [$clog2(LINE_SIZE)-1:0]  o_mem_addr,
    output logic [clb_pkg::BYTE_W-1:0]    o_mem_wdata,
    input  logic [clb_pkg::BYTE_W-1:0]    i_mem_rdata,
    // Result item
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output clb_pkg::t_result              o_res
);

    localparam int AW = $clog2(LINE_SIZE);
    localparam int LW = (AW > clb_pkg::SIZE_W) ? AW : clb_pkg::SIZE_W;
    localparam logic [AW-1:0]             CNT_MAX  = AW'(LINE_SIZE - 1);
    localparam logic [AW-1:0]             LAST_IDX = AW'(LINE_SIZE - 1);
    localparam logic [AW:0]               LS_EXT   = (AW + 1)'(LINE_SIZE);
    localparam logic [clb_pkg::SIZE_W-1:0] MAX_RD  = clb_pkg::SIZE_W'(MAX_READ);

    clb_pkg::t_state                r_state, n_state;
    logic [AW-1:0]                  r_head, n_head;
    logic [AW-1:0]                  r_count, n_count;
    logic [clb_pkg::LINE_W-1:0]     r_lines, n_lines;
    logic [clb_pkg::SIZE_W-1:0]     r_left, n_left;
    clb_pkg::t_result               r_res, n_res;

    logic                           cooked;
    logic [clb_pkg::BYTE_W-1:0]     ch_st;
    logic [clb_pkg::SIZE_W-1:0]     size_cl;
    logic [LW-1:0]                  cnt_x;
    logic [LW-1:0]                  size_x;
    logic [clb_pkg::SIZE_W-1:0]     read_len;
    logic                           load;
    clb_pkg::t_status               res_status;
    logic [clb_pkg::BYTE_W-1:0]     res_data;
    logic                           res_echo;
    logic                           res_last;

    // Circular slot of an offset from the head.
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                              input logic [AW-1:0] offset);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, offset};
        if (sum >= LS_EXT) begin
            sum = sum - LS_EXT;
        end
        return sum[AW-1:0];
    endfunction

    // Decoded item fields.
    always_comb begin
        cooked  = (i_mode == clb_pkg::MODE_COOKED);
        ch_st   = (cooked && i_key == clb_pkg::CH_CR) ? clb_pkg::CH_LF : i_key;
        size_cl = (i_size > MAX_RD) ? MAX_RD : i_size;
        cnt_x   = LW'(r_count);
        size_x  = LW'(size_cl);
        read_len = (cnt_x < size_x) ? clb_pkg::SIZE_W'(cnt_x) : size_cl;
    end

    // Next state, pointer updates, store access and result formation.
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_lines     = r_lines;
        n_left      = r_left;
        n_res       = r_res;
        o_mem_we    = 1'b0;
        o_mem_addr  = r_head;
        o_mem_wdata = ch_st;
        load        = 1'b0;
        res_status  = clb_pkg::ST_IGNORED;
        res_data    = clb_pkg::CH_NUL;
        res_echo    = 1'b0;
        res_last    = 1'b1;

        case (r_state)
            clb_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_op == clb_pkg::OP_APPEND) begin
                        if (cooked && i_key == clb_pkg::CH_ERASE) begin
                            if (r_count != '0) begin
                                o_mem_addr = slot_of(r_head, r_count - AW'(1));
                                n_state    = clb_pkg::S_ERASE_RD;
                            end else begin
                                load     = 1'b1;
                                res_data = clb_pkg::CH_ERASE;
                            end
                        end else if (ch_st == clb_pkg::CH_NUL) begin
                            load = 1'b1;
                        end else if (r_count >= CNT_MAX) begin
                            load       = 1'b1;
                            res_status = clb_pkg::ST_OVERFLOW;
                            res_data   = ch_st;
                        end else begin
                            o_mem_we   = 1'b1;
                            o_mem_addr = slot_of(r_head, r_count);
                            n_count    = r_count + AW'(1);
                            if (cooked && ch_st == clb_pkg::CH_LF &&
                                r_lines != clb_pkg::LINE_CNT_MAX) begin
                                n_lines = r_lines + clb_pkg::LINE_W'(1);
                            end
                            load       = 1'b1;
                            res_status = clb_pkg::ST_STORED;
                            res_data   = ch_st;
                            res_echo   = cooked;
                        end
                    end else begin
                        if (size_cl == '0) begin
                            load       = 1'b1;
                            res_status = clb_pkg::ST_READ_EMPTY;
                        end else if (cooked && r_lines == '0) begin
                            load       = 1'b1;
                            res_status = clb_pkg::ST_WOULD_BLK;
                        end else if (read_len == '0) begin
                            load       = 1'b1;
                            res_status = clb_pkg::ST_READ_EMPTY;
                        end else begin
                            n_left  = read_len;
                            n_state = clb_pkg::S_READ_RD;
                        end
                    end
                end
            end
            clb_pkg::S_ERASE_RD: begin
                load = 1'b1;
                if (i_mem_rdata != clb_pkg::CH_LF) begin
                    n_count    = r_count - AW'(1);
                    res_status = clb_pkg::ST_ERASED;
                    res_data   = i_mem_rdata;
                end else begin
                    res_data = clb_pkg::CH_ERASE;
                end
            end
            clb_pkg::S_READ_RD: begin
                load       = 1'b1;
                n_head     = (r_head == LAST_IDX) ? '0 : r_head + AW'(1);
                n_count    = r_count - AW'(1);
                n_left     = r_left - clb_pkg::SIZE_W'(1);
                if (cooked && i_mem_rdata == clb_pkg::CH_LF && r_lines != '0) begin
                    n_lines = r_lines - clb_pkg::LINE_W'(1);
                end
                res_status = clb_pkg::ST_READ_BYTE;
                res_data   = i_mem_rdata;
                res_last   = (r_left == clb_pkg::SIZE_W'(1)) ||
                             (cooked && i_mem_rdata == clb_pkg::CH_LF);
            end
            clb_pkg::S_OUT: begin
                // The store is addressed at the head so the next byte is ready next cycle.
                if (i_res_ready) begin
                    n_state = r_res.last ? clb_pkg::S_IDLE : clb_pkg::S_READ_RD;
                end
            end
            default: begin
                n_state = clb_pkg::S_IDLE;
            end
        endcase

        if (load) begin
            n_res.status     = res_status;
            n_res.data_byte  = res_data;
            n_res.echo       = res_echo;
            n_res.last       = res_last;
            n_res.ready_res  = cooked ? (n_lines != '0) : (n_count != '0);
            n_res.fill_level = clb_pkg::FILL_W'(n_count);
            n_state          = clb_pkg::S_OUT;
        end
    end

    // Control state and buffer pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= clb_pkg::S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_lines <= '0;
        end else if (i_clear) begin
            r_state <= n_state;
            r_head  <= '0;
            r_count <= '0;
            r_lines <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_lines <= n_lines;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_left <= n_left;
        r_res  <= n_res;
    end

    assign o_idle      = (r_state == clb_pkg::S_IDLE);
    assign o_in_ready  = (r_state == clb_pkg::S_IDLE);
    assign o_res_valid = (r_state == clb_pkg::S_OUT);
    assign o_res       = r_res;

    // The held byte count stays inside the store.
    `CLB_ASSERT(a_count_range, (r_count <= CNT_MAX), "byte count beyond buffer capacity")
    // Counted lines always have bytes behind them.
    `CLB_ASSERT(a_lines_need_bytes, (r_lines != '0 |-> r_count != '0), "lines counted in an empty buffer")
    // The final result of an item returns the controller to idle once taken.
    `CLB_ASSERT(a_last_ends_item, (o_res_valid && i_res_ready && r_res.last |=> o_idle), "item did not end on its last result")
    // A write to the store only happens on an accepted append.
    `CLB_ASSERT(a_write_on_append, (o_mem_we |-> i_in_valid && o_in_ready && i_op == clb_pkg::OP_APPEND), "store written outside an append")
    // Reset leaves the controller idle.
    `CLB_ASSERT_ALWAYS(a_reset_idle, (!i_rst_n |=> r_state == clb_pkg::S_IDLE), "controller not idle after reset")

endmodule

[rtl/console_line_buffer.sv]
// Console line buffer: a keyboard byte store with cooked, rare and raw line discipline.
// An append gives its result in the cycle after acceptance; a cooked erase of a non-empty
// buffer first reads the last byte in S_ERASE_RD. A read that returns bytes fetches each
// in S_READ_RD, after acceptance and after each previous byte is taken (registered reads).
// The next item is accepted in the cycle after the previous item's last result is taken.
// Reset (synchronous, active low) empties the buffer and selects cooked mode; data is kept.
`timescale 1ns / 1ps

module console_line_buffer #(
    parameter int LINE_SIZE = clb_pkg::LINE_SIZE_DEF,
    parameter int MAX_READ  = clb_pkg::MAX_READ_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // key_byte [7:0], read_size [14:8], zero [15]
    input  logic [0:0]  i_s_tuser,   // op [0]
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // data_byte [7:0], echo [8], ready_res [9],
                                     // fill_level [17:10], zero [23:18]
    output logic [2:0]  o_m_tuser,   // status [2:0]
    output logic        o_m_tlast,   // last
    // Mode register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_data   // line_mode [1:0]
);

    localparam int AW = $clog2(LINE_SIZE);

    clb_pkg::t_mode               r_mode;
    logic                         cfg_clear;
    logic                         idle;
    logic                         mem_we;
    logic [AW-1:0]                mem_addr;
    logic [clb_pkg::BYTE_W-1:0]   mem_wdata;
    logic [clb_pkg::BYTE_W-1:0]   mem_rdata;
    clb_pkg::t_result             res;

    // A valid mode write replaces the mode and empties the buffer. It is taken only while
    // the controller is idle and no item is offered, so it never meets an item in flight.
    assign o_cfg_ready = idle && !i_s_tvalid;
    assign cfg_clear   = i_cfg_valid && o_cfg_ready && (i_cfg_data != clb_pkg::MODE_INVALID);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= clb_pkg::MODE_COOKED;
        end else if (cfg_clear) begin
            r_mode <= clb_pkg::t_mode'(i_cfg_data);
        end
    end

    clb_ram #(
        .WIDTH (clb_pkg::BYTE_W),
        .DEPTH (LINE_SIZE)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    clb_ctrl #(
        .LINE_SIZE (LINE_SIZE),
        .MAX_READ  (MAX_READ)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (r_mode),
        .i_clear     (cfg_clear),
        .o_idle      (idle),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_op        (i_s_tuser[0]),
        .i_key       (i_s_tdata[7:0]),
        .i_size      (i_s_tdata[14:8]),
        .o_mem_we    (mem_we),
        .o_mem_addr  (mem_addr),
        .o_mem_wdata (mem_wdata),
        .i_mem_rdata (mem_rdata),
        .o_res_valid (o_m_tvalid),
        .i_res_ready (i_m_tready),
        .o_res       (res)
    );

    // Pack the result item onto the stream.
    assign o_m_tdata = {6'd0, res.fill_level, res.ready_res, res.echo, res.data_byte};
    assign o_m_tuser = res.status;
    assign o_m_tlast = res.last;

endmodule

[tb/sv/console_line_buffer_tb.sv]
// Self-checking testbench for the console line buffer: stream stimulus and result prediction.
`timescale 1ns / 1ps

module console_line_buffer_tb;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int LONG_HOLD   = 400;
    localparam int TAIL_CYCLES = 20;
    localparam int STORE_FULL  = clb_pkg::LINE_SIZE_DEF - 1;
    localparam int PHASE_ITEMS = 10;

    // One keyboard or read item as it enters the block.
    typedef struct packed {
        clb_pkg::t_op op;
        logic [7:0]   key;
        logic [6:0]   size;
    } t_key_item;

    // One result item as the line discipline should produce it.
    typedef struct {
        clb_pkg::t_status status;
        logic [7:0]       data;
        logic             echo;
        logic             last;
        logic             poll;
        logic [7:0]       fill;
    } t_line_result;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata   = '0;
    logic [0:0]  i_s_tuser   = '0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [23:0] o_m_tdata;
    logic [2:0]  o_m_tuser;
    logic        o_m_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_data  = '0;

    // Pending stimulus and the results the line discipline still owes.
    t_key_item    pending_items[$];
    t_line_result results_due[$];

    // Shadow copy of the buffer state.
    logic [7:0]     kb_store [0:clb_pkg::LINE_SIZE_DEF-1];
    logic [7:0]     kb_head  = '0;
    logic [7:0]     kb_count = '0;
    logic [7:0]     kb_lines = '0;
    clb_pkg::t_mode mode_now = clb_pkg::MODE_COOKED;

    // Handshake bookkeeping shared between the clocked processes.
    t_key_item    staged;
    t_key_item    shown;
    t_line_result want;
    logic         item_loaded  = 1'b0;
    logic         item_taken   = 1'b0;
    logic         result_taken = 1'b0;
    logic         next_valid;
    logic         no_idle      = 1'b0;
    logic         hold_request = 1'b0;
    int           tx_wait      = 0;
    int           rx_wait      = 0;
    int           rx_hold      = 0;
    int           mismatches   = 0;
    int           cycle_count  = 0;
    int           items_queued = 0;
    int           phase_start;
    int           phase;
    int           k;
    int           pick;

    console_line_buffer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    // Clock generation.
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Queue one result, with the poll flag and fill level taken after the state change.
    task automatic owe(input clb_pkg::t_status st, input logic [7:0] data, input logic echo,
                       input logic last);
        t_line_result r;
        r.status = st;
        r.data   = data;
        r.echo   = echo;
        r.last   = last;
        r.poll   = (mode_now == clb_pkg::MODE_COOKED) ? (kb_lines != 0) : (kb_count != 0);
        r.fill   = kb_count;
        results_due.push_back(r);
    endtask

    // A key byte: erase and CR handling in cooked mode, then store, ignore or drop.
    task automatic discipline_append(input logic [7:0] key);
        logic [7:0] ch;
        logic [7:0] slot;
        logic [7:0] gone;
        ch = key;
        if (mode_now == clb_pkg::MODE_COOKED && ch == clb_pkg::CH_ERASE) begin
            slot = kb_head + kb_count - 8'd1;
            if (kb_count != 0 && kb_store[slot] != clb_pkg::CH_LF) begin
                gone           = kb_store[slot];
                kb_store[slot] = clb_pkg::CH_NUL;
                kb_count       = kb_count - 8'd1;
                owe(clb_pkg::ST_ERASED, gone, 1'b0, 1'b1);
            end else begin
                owe(clb_pkg::ST_IGNORED, clb_pkg::CH_ERASE, 1'b0, 1'b1);
            end
        end else begin
            if (mode_now == clb_pkg::MODE_COOKED && ch == clb_pkg::CH_CR) ch = clb_pkg::CH_LF;
            if (ch == clb_pkg::CH_NUL) begin
                owe(clb_pkg::ST_IGNORED, clb_pkg::CH_NUL, 1'b0, 1'b1);
            end else if (kb_count >= STORE_FULL) begin
                owe(clb_pkg::ST_OVERFLOW, ch, 1'b0, 1'b1);
            end else begin
                slot           = kb_head + kb_count;
                kb_store[slot] = ch;
                kb_count       = kb_count + 8'd1;
                if (mode_now == clb_pkg::MODE_COOKED && ch == clb_pkg::CH_LF &&
                    kb_lines != clb_pkg::LINE_CNT_MAX)
                    kb_lines = kb_lines + 8'd1;
                owe(clb_pkg::ST_STORED, ch, mode_now == clb_pkg::MODE_COOKED, 1'b1);
            end
        end
    endtask

    // A read request: a cooked read stops after the first newline inside the window.
    task automatic discipline_read(input logic [6:0] req);
        int         sz;
        int         len;
        int         i;
        logic [7:0] slot;
        logic [7:0] b;
        sz = (req > clb_pkg::MAX_READ_DEF) ? clb_pkg::MAX_READ_DEF : int'(req);
        if (sz == 0) begin
            owe(clb_pkg::ST_READ_EMPTY, clb_pkg::CH_NUL, 1'b0, 1'b1);
        end else if (mode_now == clb_pkg::MODE_COOKED && kb_lines == 0) begin
            owe(clb_pkg::ST_WOULD_BLK, clb_pkg::CH_NUL, 1'b0, 1'b1);
        end else begin
            len = (int'(kb_count) < sz) ? int'(kb_count) : sz;
            if (mode_now == clb_pkg::MODE_COOKED) begin
                for (i = 0; i < len; i++) begin
                    slot = kb_head + 8'(i);
                    if (kb_store[slot] == clb_pkg::CH_LF) len = i + 1;
                end
            end
            if (len == 0) begin
                owe(clb_pkg::ST_READ_EMPTY, clb_pkg::CH_NUL, 1'b0, 1'b1);
            end else begin
                for (i = 0; i < len; i++) begin
                    b        = kb_store[kb_head];
                    kb_head  = kb_head + 8'd1;
                    kb_count = kb_count - 8'd1;
                    if (mode_now == clb_pkg::MODE_COOKED && b == clb_pkg::CH_LF &&
                        kb_lines != 0)
                        kb_lines = kb_lines - 8'd1;
                    owe(clb_pkg::ST_READ_BYTE, b, 1'b0, i == len - 1);
                end
            end
        end
    endtask

    // A mode write empties the buffer; the code that is not a mode changes nothing.
    task automatic apply_mode(input logic [1:0] value);
        if (value != clb_pkg::MODE_INVALID) begin
            mode_now = clb_pkg::t_mode'(value);
            kb_head  = '0;
            kb_count = '0;
            kb_lines = '0;
        end
    endtask

    task automatic check_field(input string what, input logic [7:0] expv,
                               input logic [7:0] got);
        if (got !== expv) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, expv, got);
        end
    endtask

    // Input acceptance feeds the shadow state; result acceptance is checked against it.
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            item_taken = 1'b1;
            if (shown.op == clb_pkg::OP_APPEND) discipline_append(shown.key);
            else discipline_read(shown.size);
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            result_taken = 1'b1;
            if (results_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual status %0d data %0d",
                         $time, o_m_tuser, o_m_tdata[7:0]);
            end else begin
                want = results_due.pop_front();
                check_field("status", 8'(want.status), 8'(o_m_tuser));
                check_field("data_byte", want.data, o_m_tdata[7:0]);
                check_field("echo", 8'(want.echo), 8'(o_m_tdata[8]));
                check_field("last", 8'(want.last), 8'(o_m_tlast));
                check_field("ready_res", 8'(want.poll), 8'(o_m_tdata[9]));
                check_field("fill_level", want.fill, o_m_tdata[17:10]);
            end
        end
    end

    // Input driver: each item waits a random gap before it is offered, none while no_idle is set.
    always @(negedge i_clk) begin
        next_valid = i_s_tvalid;
        if (item_taken) begin
            item_taken = 1'b0;
            next_valid = 1'b0;
        end
        if (!next_valid) begin
            if (!item_loaded && pending_items.size() != 0) begin
                staged      = pending_items.pop_front();
                item_loaded = 1'b1;
                tx_wait     = no_idle ? 0 : $urandom_range(0, 9);
            end
            if (item_loaded) begin
                if (tx_wait == 0) begin
                    item_loaded = 1'b0;
                    next_valid  = 1'b1;
                    shown       = staged;
                    i_s_tdata  <= {1'b0, staged.size, staged.key};
                    i_s_tuser  <= staged.op;
                end else begin
                    tx_wait--;
                end
            end
        end
        i_s_tvalid <= next_valid;
    end

    // Result receiver: a random stall after each item, and one long hold on request.
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            rx_hold      = LONG_HOLD;
        end
        if (result_taken) begin
            result_taken = 1'b0;
            rx_wait      = no_idle ? 0 : $urandom_range(0, 9);
        end
        if (rx_hold > 0) begin
            rx_hold--;
            i_m_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("console_line_buffer_tb NOT OK");
            $finish;
        end
    end

    task automatic push_key(input logic [7:0] key);
        t_key_item it;
        it.op   = clb_pkg::OP_APPEND;
        it.key  = key;
        it.size = 7'($urandom_range(0, 127));
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic push_read(input logic [6:0] size);
        t_key_item it;
        it.op   = clb_pkg::OP_READ;
        it.key  = 8'($urandom_range(0, 255));
        it.size = size;
        pending_items.push_back(it);
        items_queued++;
    endtask

    // A printable-or-binary byte with no special meaning in any mode.
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255));
        while (b == clb_pkg::CH_ERASE || b == clb_pkg::CH_CR || b == clb_pkg::CH_LF);
        return b;
    endfunction

    // Mostly short reads, with empty and oversized requests mixed in.
    function automatic logic [6:0] read_len();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 7'd0;
        if (r == 1) return 7'($urandom_range(64, 127));
        return 7'($urandom_range(1, 20));
    endfunction

    // A short edited line closed by CR or LF.
    task automatic push_line();
        int n;
        int j;
        n = $urandom_range(0, 8);
        for (j = 0; j < n; j++) begin
            if ($urandom_range(0, 6) == 0) push_key(clb_pkg::CH_ERASE);
            push_key(plain_byte());
        end
        push_key($urandom_range(0, 1) ? clb_pkg::CH_CR : clb_pkg::CH_LF);
    endtask

    // Wait until every offered item is in and every owed result has come out.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_items.size() != 0 || item_loaded || i_s_tvalid ||
               results_due.size() != 0);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic [1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        apply_mode(value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Stimulus sequence.
    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Cooked mode after reset: blocking, erase rules, CR conversion, read windows.
        push_read(7'd10);
        push_read(7'd0);
        push_key(clb_pkg::CH_NUL);
        push_key(clb_pkg::CH_ERASE);
        push_key(8'h61);
        push_key(8'hFF);
        push_key(clb_pkg::CH_ERASE);
        push_key(clb_pkg::CH_CR);
        push_key(clb_pkg::CH_ERASE);
        push_key(8'h62);
        push_read(7'd1);
        push_read(7'd127);
        push_read(7'd64);
        push_key(clb_pkg::CH_LF);
        push_read(7'd64);
        wait_drained();

        // Rare mode stores erase and CR as they are; an invalid mode keeps the buffer.
        write_mode(clb_pkg::MODE_RARE);
        push_key(clb_pkg::CH_ERASE);
        push_key(clb_pkg::CH_CR);
        push_key(clb_pkg::CH_NUL);
        push_key(8'h80);
        push_read(7'd0);
        push_read(7'd2);
        push_read(7'd64);
        push_read(7'd5);
        push_key(8'h55);
        wait_drained();
        write_mode(clb_pkg::MODE_INVALID);
        push_read(7'd64);
        wait_drained();

        // Raw mode filled to the brim while the receiver holds off, then long and short reads.
        write_mode(clb_pkg::MODE_RAW);
        hold_request = 1'b1;
        for (k = 0; k < STORE_FULL; k++) push_key(8'($urandom_range(1, 255)));
        push_key(clb_pkg::CH_ERASE);
        push_key(plain_byte());
        push_key(clb_pkg::CH_NUL);
        for (k = 0; k < 3; k++) push_read(7'($urandom_range(64, 127)));
        for (k = 0; k < 3; k++) push_read(7'($urandom_range(1, 63)));
        push_key(plain_byte());
        push_read(7'd127);
        push_read(7'd127);
        wait_drained();

        // A cooked line longer than one read window.
        write_mode(clb_pkg::MODE_COOKED);
        for (k = 0; k < 66; k++) push_key(plain_byte());
        push_key(clb_pkg::CH_CR);
        push_read(7'd64);
        push_read(7'd2);
        push_read(7'd5);
        push_read(7'd5);
        wait_drained();

        // Random phases over all mode codes.
        for (phase = 0; phase < 6; phase++) begin
            write_mode(2'($urandom_range(0, 3)));
            no_idle     = (phase == 1);
            phase_start = items_queued;
            while (items_queued - phase_start < PHASE_ITEMS) begin
                pick = $urandom_range(0, 9);
                if (mode_now == clb_pkg::MODE_COOKED) begin
                    if (pick < 6) begin
                        push_line();
                        push_read(read_len());
                    end else if (pick < 8) begin
                        push_read(read_len());
                    end else begin
                        push_key(8'($urandom_range(0, 255)));
                    end
                end else if (pick < 6) begin
                    push_key(8'($urandom_range(0, 255)));
                end else begin
                    push_read(read_len());
                end
                // In phase 3, let the block empty out completely mid-phase.
                if (phase == 3 && items_queued - phase_start >= 5 &&
                    items_queued - phase_start < 7)
                    wait_drained();
            end
            wait_drained();
        end
        no_idle = 1'b0;

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("console_line_buffer_tb OK");
        end else begin
            $display("console_line_buffer_tb NOT OK");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/clb_pkg.sv
rtl/clb_ram.sv
rtl/clb_ctrl.sv
rtl/console_line_buffer.sv
tb/sv/console_line_buffer_tb.sv
